### rtl/cbck_pkg.sv
package cbck_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 64;
  localparam int unsigned MAX_HEIGHT_DEF = 64;

  localparam int unsigned CLIP_W = 12;

  localparam logic [6:0] SIZE_RESET = 7'd64;

  localparam logic [1:0] CMD_WR_SRC = 2'd0;
  localparam logic [1:0] CMD_WR_DST = 2'd1;
  localparam logic [1:0] CMD_RD_DST = 2'd2;
  localparam logic [1:0] CMD_BLIT   = 2'd3;

  localparam logic [1:0] OP_COPY  = 2'd0;
  localparam logic [1:0] OP_KEY   = 2'd1;
  localparam logic [1:0] OP_BLEND = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [7:0] REG_DEST_WIDTH    = 8'd0;
  localparam logic [7:0] REG_DEST_HEIGHT   = 8'd1;
  localparam logic [7:0] REG_SOURCE_WIDTH  = 8'd2;
  localparam logic [7:0] REG_SOURCE_HEIGHT = 8'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [6:0]        rect_width;
    logic [6:0]        rect_height;
    logic [5:0]        from_x;
    logic [5:0]        from_y;
    logic [1:0]        blend_op;
    logic [31:0]       pixel_in;
  } item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic [6:0]  drawn_width;
    logic [6:0]  drawn_height;
    logic        nothing_drawn;
  } result_t;

  typedef enum logic [2:0] {
    K_WR_SRC = 3'd0,
    K_WR_DST = 3'd1,
    K_READ   = 3'd2,
    K_ZERO   = 3'd3,
    K_EMPTY  = 3'd4,
    K_REPORT = 3'd5,
    K_BLIT   = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  x;
    logic [6:0]  y;
    logic [6:0]  sx;
    logic [6:0]  sy;
    logic [6:0]  w;
    logic [6:0]  h;
    logic [1:0]  op;
    logic [31:0] pixel;
  } desc_t;

  function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] s,
                                               input logic [7:0] d);
    logic [15:0] sum;
    logic [16:0] adj;
    sum = a * s + (8'd255 - a) * d;
    adj = {1'b0, sum} + {9'b0, sum[15:8]} + 17'd1;
    return adj[15:8];
  endfunction

endpackage

### rtl/cbck_front.sv
module cbck_front #(
  parameter int unsigned MAX_WIDTH  = cbck_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = cbck_pkg::MAX_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [7:0]      cfg_index,
  input  logic [6:0]      cfg_data,
  input  cbck_pkg::item_t item,
  output cbck_pkg::desc_t desc
);

  logic [6:0] dest_width, dest_height, source_width, source_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width    <= cbck_pkg::SIZE_RESET;
      dest_height   <= cbck_pkg::SIZE_RESET;
      source_width  <= cbck_pkg::SIZE_RESET;
      source_height <= cbck_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cbck_pkg::REG_DEST_WIDTH:    dest_width    <= cfg_data;
        cbck_pkg::REG_DEST_HEIGHT:   dest_height   <= cfg_data;
        cbck_pkg::REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        cbck_pkg::REG_SOURCE_HEIGHT: source_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [cbck_pkg::CLIP_W-1:0] sw, sh, dw, dh, w, h, x0, y0, sx, sy;
  logic in_surf;

  always_comb begin
    sw = (32'(source_width) > MAX_WIDTH) ? cbck_pkg::CLIP_W'(MAX_WIDTH)
                                         : cbck_pkg::CLIP_W'(source_width);
    sh = (32'(source_height) > MAX_HEIGHT) ? cbck_pkg::CLIP_W'(MAX_HEIGHT)
                                           : cbck_pkg::CLIP_W'(source_height);
    dw = (32'(dest_width) > MAX_WIDTH) ? cbck_pkg::CLIP_W'(MAX_WIDTH)
                                       : cbck_pkg::CLIP_W'(dest_width);
    dh = (32'(dest_height) > MAX_HEIGHT) ? cbck_pkg::CLIP_W'(MAX_HEIGHT)
                                         : cbck_pkg::CLIP_W'(dest_height);
    w  = cbck_pkg::CLIP_W'(item.rect_width);
    h  = cbck_pkg::CLIP_W'(item.rect_height);
    x0 = cbck_pkg::CLIP_W'(item.pos_x);
    y0 = cbck_pkg::CLIP_W'(item.pos_y);
    sx = cbck_pkg::CLIP_W'(item.from_x);
    sy = cbck_pkg::CLIP_W'(item.from_y);
    // source bounds first, then destination; left/top clip advances the source start
    if (sx + w > sw) w = sw - sx;
    if (sy + h > sh) h = sh - sy;
    if (x0 < 0) begin
      w  = w + x0;
      sx = sx - x0;
      x0 = '0;
    end
    if (y0 < 0) begin
      h  = h + y0;
      sy = sy - y0;
      y0 = '0;
    end
    if (x0 + w > dw) w = dw - x0;
    if (y0 + h > dh) h = dh - y0;

    in_surf = !item.pos_x[7] && !item.pos_y[7] &&
              (32'(item.pos_x[6:0]) < MAX_WIDTH) && (32'(item.pos_y[6:0]) < MAX_HEIGHT);

    desc.x     = item.pos_x[6:0];
    desc.y     = item.pos_y[6:0];
    desc.sx    = sx[6:0];
    desc.sy    = sy[6:0];
    desc.w     = w[6:0];
    desc.h     = h[6:0];
    desc.op    = item.blend_op;
    desc.pixel = item.pixel_in;
    case (item.cmd)
      cbck_pkg::CMD_WR_SRC: desc.kind = in_surf ? cbck_pkg::K_WR_SRC : cbck_pkg::K_ZERO;
      cbck_pkg::CMD_WR_DST: desc.kind = in_surf ? cbck_pkg::K_WR_DST : cbck_pkg::K_ZERO;
      cbck_pkg::CMD_RD_DST: desc.kind = in_surf ? cbck_pkg::K_READ : cbck_pkg::K_ZERO;
      default: begin
        if (w <= 0 || h <= 0) begin
          desc.kind = cbck_pkg::K_EMPTY;
        end else if (item.blend_op == cbck_pkg::OP_NONE) begin
          desc.kind = cbck_pkg::K_REPORT;
        end else begin
          desc.kind = cbck_pkg::K_BLIT;
        end
        desc.x = x0[6:0];
        desc.y = y0[6:0];
      end
    endcase
  end

endmodule

### rtl/cbck_queue.sv
module cbck_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  cbck_pkg::desc_t wr_data,
  output logic            full,
  input  logic            rd,
  output logic            valid,
  output cbck_pkg::desc_t rd_data
);

  cbck_pkg::desc_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign valid   = count != 2'd0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= !wr_ptr;
      if (rd) rd_ptr <= !rd_ptr;
      if (wr && !rd) count <= count + 2'd1;
      else if (rd && !wr) count <= count - 2'd1;
    end
  end

endmodule

### rtl/cbck_back.sv
module cbck_back #(
  parameter int unsigned MAX_WIDTH  = cbck_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = cbck_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cbck_pkg::desc_t   q_desc,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output cbck_pkg::result_t result
);

  localparam int unsigned WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_WALK  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [31:0] src_mem [WORDS];
  logic [31:0] dst_mem [WORDS];
  logic [31:0] src_rdata, dst_rdata;

  logic [AW-1:0] head_addr, head_src_addr;
  logic [AW-1:0] s_addr, s_row, d_addr, d_row, p_addr, dst_raddr, dst_waddr;
  logic [6:0]    col, row, blit_w, blit_h;
  logic [1:0]    blit_op;
  logic          p_valid, out_valid, take, push, dst_wen;
  logic [31:0]   blended, dst_wdata;
  cbck_pkg::result_t res_next;

  assign head_addr     = AW'(32'(q_desc.y) * MAX_WIDTH + 32'(q_desc.x));
  assign head_src_addr = AW'(32'(q_desc.sy) * MAX_WIDTH + 32'(q_desc.sx));

  assign empty = !out_valid;
  assign take  = (state == S_IDLE) && q_valid && (!out_valid || pop);
  assign q_rd  = take;

  assign dst_raddr = (state == S_IDLE) ? head_addr : d_addr;

  always_ff @(posedge clk) begin
    src_rdata <= src_mem[s_addr];
    dst_rdata <= dst_mem[dst_raddr];
    if (take && q_desc.kind == cbck_pkg::K_WR_SRC) src_mem[head_addr] <= q_desc.pixel;
    if (dst_wen) dst_mem[dst_waddr] <= dst_wdata;
  end

  assign blended = {8'hff,
                    cbck_pkg::blend_channel(src_rdata[31:24], src_rdata[23:16], dst_rdata[23:16]),
                    cbck_pkg::blend_channel(src_rdata[31:24], src_rdata[15:8], dst_rdata[15:8]),
                    cbck_pkg::blend_channel(src_rdata[31:24], src_rdata[7:0], dst_rdata[7:0])};

  always_comb begin
    if (take && q_desc.kind == cbck_pkg::K_WR_DST) begin
      dst_wen   = 1'b1;
      dst_waddr = head_addr;
      dst_wdata = q_desc.pixel;
    end else begin
      dst_waddr = p_addr;
      dst_wdata = (blit_op == cbck_pkg::OP_BLEND) ? blended : src_rdata;
      dst_wen   = p_valid && (blit_op != cbck_pkg::OP_KEY || src_rdata[31:24] != 8'd0);
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    res_next   = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (q_desc.kind)
            cbck_pkg::K_READ: state_next = S_READ;
            cbck_pkg::K_BLIT: state_next = S_WALK;
            cbck_pkg::K_EMPTY: begin
              push                   = 1'b1;
              res_next.nothing_drawn = 1'b1;
            end
            cbck_pkg::K_REPORT: begin
              push                  = 1'b1;
              res_next.drawn_width  = q_desc.w;
              res_next.drawn_height = q_desc.h;
            end
            default: push = 1'b1;
          endcase
        end
      end
      S_READ: begin
        push               = 1'b1;
        res_next.pixel_out = dst_rdata;
        state_next         = S_IDLE;
      end
      S_WALK: begin
        if (col == blit_w - 7'd1 && row == blit_h - 7'd1) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        push                  = 1'b1;
        res_next.drawn_width  = blit_w;
        res_next.drawn_height = blit_h;
        state_next            = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      blit_w  <= q_desc.w;
      blit_h  <= q_desc.h;
      blit_op <= q_desc.op;
      s_addr  <= head_src_addr;
      s_row   <= head_src_addr;
      d_addr  <= head_addr;
      d_row   <= head_addr;
      col     <= '0;
      row     <= '0;
    end else if (state == S_WALK) begin
      if (col == blit_w - 7'd1) begin
        col    <= '0;
        row    <= row + 7'd1;
        s_row  <= s_row + ROW_STEP;
        s_addr <= s_row + ROW_STEP;
        d_row  <= d_row + ROW_STEP;
        d_addr <= d_row + ROW_STEP;
      end else begin
        col    <= col + 7'd1;
        s_addr <= s_addr + AW'(1);
        d_addr <= d_addr + AW'(1);
      end
    end
    p_addr <= d_addr;
    if (push) result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= (state == S_WALK);
      if (push) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

endmodule

### rtl/clipped_blit_color_key_alpha.sv
// Clipped 2D blitter with color key and alpha blend on ARGB8888 surfaces.
// Input channel: drive item and raise push; the item transfers on a clock edge
// with push high and full low. Commands load a source or destination pixel,
// read a destination pixel, or blit a rectangle clipped to both surfaces.
// Result channel: while empty is low the oldest result sits on result; raise
// pop to transfer it. Every command yields exactly one result, in order.
// Configuration: cfg_index/cfg_data transfer when cfg_valid and cfg_ready are
// high (cfg_ready is always high); write only while the block is idle.
// Flow: a transfer is registered in the queue, taken by the idle sequencer
// and then registered on result; a read adds a destination memory read, and a
// blit walks one pixel per cycle through the source/destination memory read
// ports followed by a one-pixel write stage, then reports its drawn size.
// The sequencer takes no new command until it is idle and the result is free.
// A two-entry queue between classifier and sequencer takes two more commands
// while a result waits on a stalled receiver; then full rises and holds the
// input until pop frees the result. Reset empties queue and result, returns
// the surface sizes to 64; pixel memories are not cleared.
module clipped_blit_color_key_alpha #(
  parameter int unsigned MAX_WIDTH  = cbck_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = cbck_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cbck_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output cbck_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [6:0]        cfg_data
);

  cbck_pkg::desc_t desc, q_desc;
  logic q_valid, q_rd;

  // config regs always accept a transfer
  assign cfg_ready = 1'b1;

  cbck_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(item), .desc(desc)
  );

  // hold classified commands until the sequencer is free
  cbck_queue u_queue (
    .clk(clk), .rst(rst), .wr(push && !full), .wr_data(desc), .full(full),
    .rd(q_rd), .valid(q_valid), .rd_data(q_desc)
  );

  cbck_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_desc(q_desc), .q_rd(q_rd),
    .empty(empty), .pop(pop), .result(result)
  );

  a_empty_blit_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.nothing_drawn |-> result.drawn_width == 7'd0 &&
                                       result.drawn_height == 7'd0)
    else $error("empty blit reports a drawn size");

  a_size_pair: assert property (@(posedge clk) disable iff (rst)
    !empty && result.drawn_width != 7'd0 |-> result.drawn_height != 7'd0 &&
                                            !result.nothing_drawn)
    else $error("inconsistent drawn size");

  a_width_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> 32'(result.drawn_width) <= MAX_WIDTH &&
               32'(result.drawn_height) <= MAX_HEIGHT)
    else $error("drawn size exceeds surface");

endmodule

### dv/blit_scoreboard.sv
`timescale 1ns / 1ps

module blit_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  cbck_pkg::item_t   item,
  input  logic              empty,
  input  logic              pop,
  input  cbck_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  output int                n_errors,
  output int                n_pending
);

  localparam int SIDE = 64;

  logic [31:0]       src_img [SIDE*SIDE];
  logic [31:0]       dst_img [SIDE*SIDE];
  logic [6:0]        dst_w_reg, dst_h_reg, src_w_reg, src_h_reg;
  cbck_pkg::result_t expected_q [$];

  function automatic bit on_surface(int x, int y);
    return x >= 0 && x < SIDE && y >= 0 && y < SIDE;
  endfunction

  function automatic int clamp64(logic [6:0] v);
    return (int'(v) > SIDE) ? SIDE : int'(v);
  endfunction

  function automatic logic [31:0] mix_pixel(logic [31:0] s, logic [31:0] d);
    int a;
    logic [31:0] o;
    a = int'(s[31:24]);
    o = 32'hff000000;
    for (int c = 0; c < 3; c++)
      o[c*8 +: 8] = 8'((a * int'(s[c*8 +: 8]) + (255 - a) * int'(d[c*8 +: 8])) / 255);
    return o;
  endfunction

  task automatic apply_command(input cbck_pkg::item_t it, output cbck_pkg::result_t r);
    int x0, y0, sx, sy, w, h, di;
    logic [31:0] s;
    r = '0;
    x0 = int'($signed(it.pos_x));
    y0 = int'($signed(it.pos_y));
    case (it.cmd)
      cbck_pkg::CMD_WR_SRC: if (on_surface(x0, y0)) src_img[y0*SIDE + x0] = it.pixel_in;
      cbck_pkg::CMD_WR_DST: if (on_surface(x0, y0)) dst_img[y0*SIDE + x0] = it.pixel_in;
      cbck_pkg::CMD_RD_DST: if (on_surface(x0, y0)) r.pixel_out = dst_img[y0*SIDE + x0];
      default: begin
        w  = int'(it.rect_width);
        h  = int'(it.rect_height);
        sx = int'(it.from_x);
        sy = int'(it.from_y);
        // clip to the source first, then to the destination
        if (sx + w > clamp64(src_w_reg)) w = clamp64(src_w_reg) - sx;
        if (sy + h > clamp64(src_h_reg)) h = clamp64(src_h_reg) - sy;
        if (x0 < 0) begin w += x0; sx -= x0; x0 = 0; end
        if (y0 < 0) begin h += y0; sy -= y0; y0 = 0; end
        if (x0 + w > clamp64(dst_w_reg)) w = clamp64(dst_w_reg) - x0;
        if (y0 + h > clamp64(dst_h_reg)) h = clamp64(dst_h_reg) - y0;
        if (w <= 0 || h <= 0) begin
          r.nothing_drawn = 1'b1;
        end else begin
          r.drawn_width  = w[6:0];
          r.drawn_height = h[6:0];
          if (it.blend_op != cbck_pkg::OP_NONE) begin
            for (int i = 0; i < h; i++) begin
              for (int j = 0; j < w; j++) begin
                if (on_surface(sx + j, sy + i) && on_surface(x0 + j, y0 + i)) begin
                  s  = src_img[(sy + i)*SIDE + sx + j];
                  di = (y0 + i)*SIDE + x0 + j;
                  if (it.blend_op == cbck_pkg::OP_COPY) dst_img[di] = s;
                  else if (it.blend_op == cbck_pkg::OP_KEY) begin
                    if (s[31:24] != 8'd0) dst_img[di] = s;
                  end else dst_img[di] = mix_pixel(s, dst_img[di]);
                end
              end
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    cbck_pkg::result_t r, e;
    if (rst) begin
      dst_w_reg = cbck_pkg::SIZE_RESET;
      dst_h_reg = cbck_pkg::SIZE_RESET;
      src_w_reg = cbck_pkg::SIZE_RESET;
      src_h_reg = cbck_pkg::SIZE_RESET;
      expected_q.delete();
      n_errors  <= 0;
      n_pending <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected: %p", result);
          n_errors <= n_errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (result !== e) begin
            if (result.pixel_out !== e.pixel_out)
              $error("pixel_out: expected %h, actual %h", e.pixel_out, result.pixel_out);
            if (result.drawn_width !== e.drawn_width)
              $error("drawn_width: expected %0d, actual %0d",
                     e.drawn_width, result.drawn_width);
            if (result.drawn_height !== e.drawn_height)
              $error("drawn_height: expected %0d, actual %0d",
                     e.drawn_height, result.drawn_height);
            if (result.nothing_drawn !== e.nothing_drawn)
              $error("nothing_drawn: expected %0b, actual %0b",
                     e.nothing_drawn, result.nothing_drawn);
            n_errors <= n_errors + 1;
          end
        end
      end
      // an item in the same cycle as a register write still sees the old sizes
      if (push && !full) begin
        apply_command(item, r);
        expected_q.push_back(r);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbck_pkg::REG_DEST_WIDTH:    dst_w_reg = cfg_data;
          cbck_pkg::REG_DEST_HEIGHT:   dst_h_reg = cfg_data;
          cbck_pkg::REG_SOURCE_WIDTH:  src_w_reg = cfg_data;
          cbck_pkg::REG_SOURCE_HEIGHT: src_h_reg = cfg_data;
          default: ;
        endcase
      end
      n_pending <= expected_q.size();
    end
  end

endmodule

### dv/clipped_blit_color_key_alpha_tb.sv
`timescale 1ns / 1ps

module clipped_blit_color_key_alpha_tb;

  localparam int STALL_LIMIT = 20000;  // well above the longest blit
  localparam int HOLD_CYCLES = 250;
  localparam int PHASE_ITEMS = 85;
  localparam int SIDE        = 64;
  localparam int LOAD_SIDE   = 16;     // corner of both surfaces loaded up front

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  cbck_pkg::item_t   item_d = '0;
  logic              empty;
  logic              pop = 1'b0;
  cbck_pkg::result_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_index = '0;
  logic [6:0]        cfg_data = '0;

  int n_errors, n_pending;
  int snd_idle = 0;   // percent of cycles the sender idles
  int rcv_idle = 0;   // percent of cycles the receiver idles
  int hold_seq = 0;   // bump to make the receiver hold off for a long stretch
  int stall_cycles = 0;
  int n_sent = 0, n_blits = 0;

  // pixels known to hold a written value; stimulus never reads any other
  bit src_set [SIDE*SIDE];
  bit dst_set [SIDE*SIDE];
  int cur_dw = 64, cur_dh = 64, cur_sw = 64, cur_sh = 64;

  always #1 clk = ~clk;

  clipped_blit_color_key_alpha uut (
    .clk, .rst, .push, .full, .item(item_d), .empty, .pop, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  blit_scoreboard chk (
    .clk, .rst, .push, .full, .item(item_d), .empty, .pop, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .n_errors, .n_pending
  );

  // Receiver: random pop, or a long hold-off when a new request shows up.
  always @(negedge clk) begin
    static int hold_left = 0;
    static int last_seq = 0;
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_seq != last_seq) begin
      last_seq = hold_seq;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Watchdog: count cycles in which neither channel transfers.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic cbck_pkg::item_t mk(logic [1:0] c, int x, int y, int w, int h,
                                         int fx, int fy, logic [1:0] op,
                                         logic [31:0] pix);
    cbck_pkg::item_t it;
    it.cmd = c;
    it.pos_x = x[7:0];
    it.pos_y = y[7:0];
    it.rect_width = w[6:0];
    it.rect_height = h[6:0];
    it.from_x = fx[5:0];
    it.from_y = fy[5:0];
    it.blend_op = op;
    it.pixel_in = pix;
    return it;
  endfunction

  function automatic int clamp_side(int v);
    return (v > SIDE) ? SIDE : v;
  endfunction

  function automatic bit on_surface(int x, int y);
    return x >= 0 && x < SIDE && y >= 0 && y < SIDE;
  endfunction

  // Clip a blit against the current sizes; w or h <= 0 means nothing is drawn.
  function automatic void clip_blit(input cbck_pkg::item_t it, output int x0,
                                    output int y0, output int sx, output int sy,
                                    output int w, output int h);
    x0 = int'($signed(it.pos_x));
    y0 = int'($signed(it.pos_y));
    w  = int'(it.rect_width);
    h  = int'(it.rect_height);
    sx = int'(it.from_x);
    sy = int'(it.from_y);
    if (sx + w > clamp_side(cur_sw)) w = clamp_side(cur_sw) - sx;
    if (sy + h > clamp_side(cur_sh)) h = clamp_side(cur_sh) - sy;
    if (x0 < 0) begin w += x0; sx -= x0; x0 = 0; end
    if (y0 < 0) begin h += y0; sy -= y0; y0 = 0; end
    if (x0 + w > clamp_side(cur_dw)) w = clamp_side(cur_dw) - x0;
    if (y0 + h > clamp_side(cur_dh)) h = clamp_side(cur_dh) - y0;
  endfunction

  // True when the item would read a pixel that was never written.
  function automatic bit reads_unset(cbck_pkg::item_t it);
    int x0, y0, sx, sy, w, h;
    bit bad;
    bad = 1'b0;
    x0 = int'($signed(it.pos_x));
    y0 = int'($signed(it.pos_y));
    if (it.cmd == cbck_pkg::CMD_RD_DST) begin
      if (on_surface(x0, y0)) bad = !dst_set[y0*SIDE + x0];
    end else if (it.cmd == cbck_pkg::CMD_BLIT && it.blend_op != cbck_pkg::OP_NONE) begin
      clip_blit(it, x0, y0, sx, sy, w, h);
      for (int i = 0; i < h; i++)
        for (int j = 0; j < w; j++) begin
          if (!src_set[(sy + i)*SIDE + sx + j]) bad = 1'b1;
          if (it.blend_op == cbck_pkg::OP_BLEND && !dst_set[(y0 + i)*SIDE + x0 + j])
            bad = 1'b1;
        end
    end
    return bad;
  endfunction

  function automatic void mark_written(cbck_pkg::item_t it);
    int x0, y0, sx, sy, w, h;
    x0 = int'($signed(it.pos_x));
    y0 = int'($signed(it.pos_y));
    case (it.cmd)
      cbck_pkg::CMD_WR_SRC: if (on_surface(x0, y0)) src_set[y0*SIDE + x0] = 1'b1;
      cbck_pkg::CMD_WR_DST: if (on_surface(x0, y0)) dst_set[y0*SIDE + x0] = 1'b1;
      cbck_pkg::CMD_BLIT: begin
        // a keyed blit may leave pixels alone, so only copy and blend count
        if (it.blend_op == cbck_pkg::OP_COPY || it.blend_op == cbck_pkg::OP_BLEND) begin
          clip_blit(it, x0, y0, sx, sy, w, h);
          for (int i = 0; i < h; i++)
            for (int j = 0; j < w; j++)
              dst_set[(y0 + i)*SIDE + x0 + j] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(9) == 0) return $urandom_range(255) - 128;
    if ($urandom_range(1) == 0) return $urandom_range(LOAD_SIDE - 1);
    return $urandom_range(63);
  endfunction

  function automatic logic [31:0] pick_pixel();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(3))
      0: p[31:24] = 8'h00;   // keyed out
      1: p[31:24] = 8'hff;
      default: ;
    endcase
    return p;
  endfunction

  function automatic cbck_pkg::item_t random_item();
    cbck_pkg::item_t it;
    it.cmd = 2'($urandom_range(3));
    it.pos_x = 8'(pick_coord());
    it.pos_y = 8'(pick_coord());
    it.rect_width = 7'($urandom_range(127));
    it.rect_height = 7'($urandom_range(127));
    it.from_x = 6'($urandom_range(63));
    it.from_y = 6'($urandom_range(63));
    it.blend_op = 2'($urandom_range(3));
    it.pixel_in = pick_pixel();
    if (it.cmd == cbck_pkg::CMD_BLIT) begin
      // mostly small rectangles near the loaded corner, rarely any size up to 127
      if ($urandom_range(49) != 0) begin
        it.rect_width = 7'($urandom_range(10));
        it.rect_height = 7'($urandom_range(10));
        it.from_x = 6'($urandom_range(LOAD_SIDE - 1));
        it.from_y = 6'($urandom_range(LOAD_SIDE - 1));
        if ($urandom_range(3) != 0) begin
          it.pos_x = 8'($urandom_range(26) - 10);
          it.pos_y = 8'($urandom_range(26) - 10);
        end
      end
    end
    return it;
  endfunction

  // Redraw until the item reads only written pixels.
  function automatic cbck_pkg::item_t safe_item();
    cbck_pkg::item_t it;
    do it = random_item(); while (reads_unset(it));
    return it;
  endfunction

  // Offer one item and hold it until it transfers; returns at a falling edge.
  task automatic send_item(input cbck_pkg::item_t it);
    while ($urandom_range(99) < snd_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item_d <= it;
    do @(posedge clk); while (full);
    @(negedge clk);
    mark_written(it);
    n_sent++;
    if (it.cmd == cbck_pkg::CMD_BLIT) n_blits++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain all results, let the block settle, then program new surface sizes.
  task automatic set_sizes(input int dw, input int dh, input int sw, input int sh);
    push <= 1'b0;
    @(negedge clk);
    wait (n_pending == 0);
    repeat (10) @(negedge clk);
    write_reg(cbck_pkg::REG_DEST_WIDTH, dw[6:0]);
    write_reg(cbck_pkg::REG_DEST_HEIGHT, dh[6:0]);
    write_reg(cbck_pkg::REG_SOURCE_WIDTH, sw[6:0]);
    write_reg(cbck_pkg::REG_SOURCE_HEIGHT, sh[6:0]);
    cur_dw = int'(dw[6:0]);
    cur_dh = int'(dh[6:0]);
    cur_sw = int'(sw[6:0]);
    cur_sh = int'(sh[6:0]);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Load a corner of both surfaces; stimulus keeps its reads inside written pixels.
    for (int y = 0; y < LOAD_SIDE; y++)
      for (int x = 0; x < LOAD_SIDE; x++) begin
        send_item(mk(cbck_pkg::CMD_WR_SRC, x, y, 0, 0, 0, 0, cbck_pkg::OP_COPY,
                     pick_pixel()));
        send_item(mk(cbck_pkg::CMD_WR_DST, x, y, 0, 0, 0, 0, cbck_pkg::OP_COPY,
                     $urandom));
      end

    // Directed: corners, out-of-range accesses, every op and clip case.
    send_item(mk(cbck_pkg::CMD_WR_DST, 0, 0, 0, 0, 0, 0, cbck_pkg::OP_COPY, 32'hffffffff));
    send_item(mk(cbck_pkg::CMD_WR_DST, 63, 63, 0, 0, 0, 0, cbck_pkg::OP_COPY, 32'h00000000));
    send_item(mk(cbck_pkg::CMD_WR_SRC, 63, 0, 0, 0, 0, 0, cbck_pkg::OP_COPY, 32'h00ff00ff));
    send_item(mk(cbck_pkg::CMD_WR_DST, -128, 127, 0, 0, 0, 0, cbck_pkg::OP_COPY,
                 32'h12345678));
    send_item(mk(cbck_pkg::CMD_WR_SRC, 64, 0, 0, 0, 0, 0, cbck_pkg::OP_COPY, 32'h12345678));
    send_item(mk(cbck_pkg::CMD_RD_DST, 0, 0, 0, 0, 0, 0, cbck_pkg::OP_COPY, 0));
    send_item(mk(cbck_pkg::CMD_RD_DST, 63, 63, 0, 0, 0, 0, cbck_pkg::OP_COPY, 0));
    send_item(mk(cbck_pkg::CMD_RD_DST, -1, 5, 0, 0, 0, 0, cbck_pkg::OP_COPY, 0));
    send_item(mk(cbck_pkg::CMD_RD_DST, 5, 64, 0, 0, 0, 0, cbck_pkg::OP_COPY, 0));
    send_item(mk(cbck_pkg::CMD_BLIT, 2, 3, 4, 4, 10, 10, cbck_pkg::OP_COPY, 0));
    send_item(mk(cbck_pkg::CMD_BLIT, 8, 8, 5, 5, 0, 0, cbck_pkg::OP_KEY, 0));
    send_item(mk(cbck_pkg::CMD_BLIT, 5, 6, 6, 3, 3, 4, cbck_pkg::OP_BLEND, 0));
    send_item(mk(cbck_pkg::CMD_BLIT, 1, 1, 7, 7, 1, 1, cbck_pkg::OP_NONE, 0));
    // left/top clip
    send_item(mk(cbck_pkg::CMD_BLIT, -3, -5, 8, 8, 4, 4, cbck_pkg::OP_COPY, 0));
    // right/bottom clip, then blend over the pixels just copied
    send_item(mk(cbck_pkg::CMD_BLIT, 60, 61, 10, 10, 0, 0, cbck_pkg::OP_COPY, 0));
    send_item(mk(cbck_pkg::CMD_BLIT, 60, 61, 10, 10, 0, 0, cbck_pkg::OP_BLEND, 0));
    // source edge
    send_item(mk(cbck_pkg::CMD_BLIT, 0, 0, 5, 5, 63, 0, cbck_pkg::OP_NONE, 0));
    // empty width, empty height
    send_item(mk(cbck_pkg::CMD_BLIT, 0, 0, 0, 5, 0, 0, cbck_pkg::OP_COPY, 0));
    send_item(mk(cbck_pkg::CMD_BLIT, 0, 0, 5, 0, 0, 0, cbck_pkg::OP_COPY, 0));
    // clipped away, beyond dest
    send_item(mk(cbck_pkg::CMD_BLIT, -128, 0, 127, 4, 0, 0, cbck_pkg::OP_COPY, 0));
    send_item(mk(cbck_pkg::CMD_BLIT, 127, 127, 4, 4, 0, 0, cbck_pkg::OP_COPY, 0));
    // whole surface
    send_item(mk(cbck_pkg::CMD_BLIT, 0, 0, 127, 127, 0, 0, cbck_pkg::OP_NONE, 0));
    send_item(mk(cbck_pkg::CMD_RD_DST, 15, 15, 0, 0, 0, 0, cbck_pkg::OP_COPY, 0));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_sizes(64, 64, 64, 64);
        1: set_sizes(127, 127, 127, 127);   // above the maximum: saturate
        2: begin
          set_sizes(0, 0, 64, 64);          // every blit empty
          write_reg(8'hff, 7'h7f);          // unknown index: ignored
        end
        3: set_sizes($urandom_range(1, 64), $urandom_range(1, 64),
                     $urandom_range(1, 64), $urandom_range(1, 64));
        4: set_sizes(40, 20, 0, 10);
        default: set_sizes($urandom_range(127), $urandom_range(127),
                           $urandom_range(127), $urandom_range(127));
      endcase
      // idle receiver first, then idle sender, then full rate
      snd_idle = (ph < 2) ? 35 : (ph < 4) ? 61 : 0;
      rcv_idle = (ph < 2) ? 61 : (ph < 4) ? 35 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 50) begin
          // stall the receiver and keep pushing writes to back up the block
          hold_seq++;
          for (int k = 0; k < 20; k++)
            send_item(mk(cbck_pkg::CMD_WR_DST, pick_coord(), pick_coord(), 0, 0, 0, 0,
                         cbck_pkg::OP_COPY, $urandom));
        end
        if (ph == 3 && n == 80) begin
          push <= 1'b0;
          @(negedge clk);
          wait (n_pending == 0);
          @(negedge clk);
        end
        send_item(safe_item());
      end
    end

    push <= 1'b0;
    wait (n_pending == 0);
    repeat (20) @(posedge clk);
    $display("Ran %0d commands (%0d blits) over 6 surface-size settings", n_sent, n_blits);
    $display("with sender and receiver idling in turn and a long receiver hold-off");
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
